[src/text_terminal_glyph_renderer_defines.svh]
// Assertion macros shared by the text terminal RTL.
`ifndef TEXT_TERMINAL_GLYPH_RENDERER_DEFINES_SVH
`define TEXT_TERMINAL_GLYPH_RENDERER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define TTGR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define TTGR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ttgr_pkg.sv]
// Shared types, codes and font table of the text terminal.
`timescale 1ns / 1ps
package ttgr_pkg;

  // Default geometry
  localparam int SCREEN_WIDTH_DEF  = 160;
  localparam int SCREEN_HEIGHT_DEF = 128;
  localparam int TEXT_COLUMNS_DEF  = 26;
  localparam int TEXT_ROWS_DEF     = 16;
  localparam int CELL_WIDTH_DEF    = 6;
  localparam int CELL_HEIGHT_DEF   = 8;

  // Pixel position width: cursor * cell * scale plus glyph offset
  localparam int POS_W   = 16;
  localparam int SCALE_W = 4;
  localparam int COLOR_W = 16;
  localparam int CFG_IDX_W = 2;

  // Operation codes
  localparam logic [2:0] OP_PUT     = 3'd0;
  localparam logic [2:0] OP_SET_POS = 3'd1;
  localparam logic [2:0] OP_GOTO    = 3'd2;
  localparam logic [2:0] OP_HOME    = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd2;

  // Character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_RETURN  = 8'h0D;
  localparam logic [7:0] GLYPH_FIRST  = 8'h20;
  localparam logic [7:0] GLYPH_LAST   = 8'h7E;
  localparam logic [7:0] GLYPH_SUBST  = 8'h3F;
  localparam int         GLYPH_COUNT  = 8'h5F;
  localparam int         GLYPH_IDX_W  = 7;

  // Cell layout: 5 glyph columns then one gap column, 7 rows each
  localparam logic [2:0] GAP_COL  = 3'd5;
  localparam logic [2:0] LAST_ROW = 3'd6;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [7:0]         h;
    logic [7:0]         w;
    logic [7:0]         y;
    logic [7:0]         x;
    logic               visible;
  } rect_t;

  // One entry per glyph, column 0 in the low byte, row 0 in bit 0 of each byte
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
    40'h0041221C00, 40'h001C224100, 40'h082A1C2A08, 40'h08083E0808,
    40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
    40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
    40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
    40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
    40'h4122140800, 40'h1414141414, 40'h0008142241, 40'h0609510102,
    40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
    40'h1C2241417F, 40'h414949497F, 40'h010109097F, 40'h325141413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
    40'h404040407F, 40'h7F0204027F, 40'h7F1008047F, 40'h3E4141413E,
    40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h4345495161, 40'h41417F0000,
    40'h2010080402, 40'h00007F4141, 40'h0402010204, 40'h4040404040,
    40'h0004020100, 40'h7854545420, 40'h384444487F, 40'h2044444438,
    40'h7F48444438, 40'h1854545438, 40'h0201097E08, 40'h3C54541408,
    40'h780404087F, 40'h00407D4400, 40'h003D444020, 40'h4428107F00,
    40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
    40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448,
    40'h2040443F04, 40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h3C5050500C, 40'h444C546444, 40'h0041360800,
    40'h00007F0000, 40'h0008364100, 40'h081C2A0808
  };

endpackage

[src/ttgr_clip.sv]
// Screen clipping of one square cell into a rectangle command.
`timescale 1ns / 1ps
module ttgr_clip #(
  parameter int SCREEN_WIDTH  = ttgr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ttgr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic [ttgr_pkg::POS_W-1:0]   pos_x,
  input  logic [ttgr_pkg::POS_W-1:0]   pos_y,
  input  logic [ttgr_pkg::SCALE_W-1:0] side,
  input  logic [ttgr_pkg::COLOR_W-1:0] color,
  output ttgr_pkg::rect_t              rect
);
  import ttgr_pkg::*;

  localparam int END_W = POS_W + 1;
  localparam logic [END_W-1:0] SW_END = END_W'(SCREEN_WIDTH);
  localparam logic [END_W-1:0] SH_END = END_W'(SCREEN_HEIGHT);

  logic             on;
  logic [END_W-1:0] end_x;
  logic [END_W-1:0] end_y;

  always_comb begin
    on    = ({1'b0, pos_x} < SW_END) && ({1'b0, pos_y} < SH_END);
    end_x = {1'b0, pos_x} + END_W'(side);
    end_y = {1'b0, pos_y} + END_W'(side);
    rect.color   = color;
    rect.visible = on;
    if (on) begin
      rect.x = pos_x[7:0];
      rect.y = pos_y[7:0];
      rect.w = (end_x > SW_END) ? (8'(SCREEN_WIDTH) - pos_x[7:0]) : 8'(side);
      rect.h = (end_y > SH_END) ? (8'(SCREEN_HEIGHT) - pos_y[7:0]) : 8'(side);
    end else begin
      rect.x = '0;
      rect.y = '0;
      rect.w = '0;
      rect.h = '0;
    end
  end

endmodule

[src/text_terminal_glyph_renderer.sv]
// Top level of the character terminal: cursor, sequencer and result register.
`timescale 1ns / 1ps
// Character terminal that turns a stream of text commands into rectangle fill
// commands for a pixel display. Each input item carries an operation in
// in_tuser: put character, set position, goto line (one-based, clamped), home
// or clear. A printable character yields 42 rectangles, the 5x7 glyph sent
// column by column and top to bottom, then a 7-cell background gap column; the
// final one has out_tlast set. Codes outside 0x20..0x7E other than newline and
// carriage return draw as '?'. Clear yields one full-screen background
// rectangle. Rectangles are clipped at the screen edge; one whose origin lies
// off screen still comes out, with out_tuser (visible) low and zero geometry.
// Sequence: a put character is accepted in IDLE, the glyph is looked up and the
// cell origin formed in ORIGIN, the 42 rectangles come out in EMIT, and the
// cursor advances in CURSOR. The 42 are paced by a single step adder that moves
// the cell position by the scale each cycle, holding while out_tready is low.
// Every other operation is done in IDLE on acceptance; clear also needs its one
// result taken. Colors and text scale come in over the cfg_ port (always
// ready) and should only be changed while the block is idle.
module text_terminal_glyph_renderer #(
  parameter int SCREEN_WIDTH  = ttgr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ttgr_pkg::SCREEN_HEIGHT_DEF,
  parameter int TEXT_COLUMNS  = ttgr_pkg::TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS     = ttgr_pkg::TEXT_ROWS_DEF,
  parameter int CELL_WIDTH    = ttgr_pkg::CELL_WIDTH_DEF,
  parameter int CELL_HEIGHT   = ttgr_pkg::CELL_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] char_code, [15:8] target_column, [23:16] target_row, [31:24] line_number
  input  logic [31:0]                     in_tdata,
  // [2:0] operation
  input  logic [2:0]                      in_tuser,
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] rect_x, [15:8] rect_y, [23:16] rect_width, [31:24] rect_height,
  // [47:32] pixel_color
  output logic [47:0]                     out_tdata,
  // [0] visible
  output logic                            out_tuser,
  output logic                            out_tlast,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ttgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttgr_pkg::COLOR_W-1:0]    cfg_data
);
  import ttgr_pkg::*;
  `include "text_terminal_glyph_renderer_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ORIGIN = 4'b0010,
    S_EMIT   = 4'b0100,
    S_CURSOR = 4'b1000
  } state_t;

  localparam int LIM_W    = 6;
  localparam int SCALES   = (1 << SCALE_W) - 1;   // scales 1..15
  localparam int CELL_M_W = 8;

  // Column and row limits per scale, worked out at elaboration; entry i is scale i+1
  logic [LIM_W-1:0] col_lim_tab [SCALES];
  logic [LIM_W-1:0] row_lim_tab [SCALES];

  for (genvar G = 0; G < SCALES; G++) begin : g_lim
    localparam int Div = G + 1;
    localparam int Cq  = TEXT_COLUMNS / Div;
    localparam int Rq  = TEXT_ROWS / Div;
    assign col_lim_tab[G] = LIM_W'((Cq == 0) ? 1 : Cq);
    assign row_lim_tab[G] = LIM_W'((Rq == 0) ? 1 : Rq);
  end

  state_t                 state_r, state_nxt;
  logic [COLOR_W-1:0]     fg_r, fg_nxt;
  logic [COLOR_W-1:0]     bg_r, bg_nxt;
  logic [SCALE_W-1:0]     scale_r, scale_nxt;
  logic [7:0]             cursor_col_r, cursor_col_nxt;
  logic [7:0]             cursor_line_r, cursor_line_nxt;
  logic [GLYPH_IDX_W-1:0] code_idx_r, code_idx_nxt;
  logic [39:0]            glyph_r, glyph_nxt;
  logic [POS_W-1:0]       x_r, x_nxt;
  logic [POS_W-1:0]       y_r, y_nxt;
  logic [POS_W-1:0]       oy_r, oy_nxt;
  logic [2:0]             col_idx_r, col_idx_nxt;
  logic [2:0]             row_idx_r, row_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rect_t                  out_rect_r, out_rect_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   out_free;
  logic                   in_fire;
  logic [LIM_W-1:0]       col_lim;
  logic [LIM_W-1:0]       row_lim;
  logic [7:0]             in_code;
  logic [7:0]             in_tcol;
  logic [7:0]             in_trow;
  logic [7:0]             in_line;
  logic [7:0]             line_inc;
  logic [7:0]             line_wrapped;
  logic [7:0]             col_inc;
  logic [7:0]             goto_line;
  logic [CELL_M_W-1:0]    cell_w_px;
  logic [CELL_M_W-1:0]    cell_h_px;
  logic [POS_W-1:0]       origin_x;
  logic [POS_W-1:0]       origin_y;
  logic                   row_last;
  logic                   cell_last;
  logic [POS_W-1:0]       step_sum;
  logic [COLOR_W-1:0]     cell_color;
  rect_t                  cell_rect;

  assign in_code = in_tdata[7:0];
  assign in_tcol = in_tdata[15:8];
  assign in_trow = in_tdata[23:16];
  assign in_line = in_tdata[31:24];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign col_lim = col_lim_tab[scale_r - 4'd1];
  assign row_lim = row_lim_tab[scale_r - 4'd1];

  // Line advance with wrap at the row limit (newline, end of row)
  assign line_inc     = cursor_line_r + 8'd1;
  assign line_wrapped = (line_inc >= 8'(row_lim)) ? 8'd0 : line_inc;
  assign col_inc      = cursor_col_r + 8'd1;

  always_comb begin
    if (in_line == 8'd0) begin
      goto_line = 8'd0;
    end else if (in_line > 8'(row_lim)) begin
      goto_line = 8'(row_lim) - 8'd1;
    end else begin
      goto_line = in_line - 8'd1;
    end
  end

  // Cell origin in pixels; two chained multiplies each, registered in ORIGIN
  assign cell_w_px = CELL_M_W'(CELL_WIDTH) * CELL_M_W'(scale_r);
  assign cell_h_px = CELL_M_W'(CELL_HEIGHT) * CELL_M_W'(scale_r);
  assign origin_x  = {8'b0, cursor_col_r} * {8'b0, cell_w_px};
  assign origin_y  = {8'b0, cursor_line_r} * {8'b0, cell_h_px};

  // Shared step adder: next row down, or next column across at column end
  assign row_last  = (row_idx_r == LAST_ROW);
  assign cell_last = row_last && (col_idx_r == GAP_COL);
  assign step_sum  = (row_last ? x_r : y_r) + POS_W'(scale_r);

  // Gap column is background; glyph bit 0 picks the color of the current cell
  assign cell_color = ((col_idx_r == GAP_COL) || !glyph_r[0]) ? bg_r : fg_r;

  ttgr_clip #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_clip (
    .pos_x (x_r),
    .pos_y (y_r),
    .side  (scale_r),
    .color (cell_color),
    .rect  (cell_rect)
  );

  always_comb begin
    state_nxt       = state_r;
    fg_nxt          = fg_r;
    bg_nxt          = bg_r;
    scale_nxt       = scale_r;
    cursor_col_nxt  = cursor_col_r;
    cursor_line_nxt = cursor_line_r;
    code_idx_nxt    = code_idx_r;
    glyph_nxt       = glyph_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    oy_nxt          = oy_r;
    col_idx_nxt     = col_idx_r;
    row_idx_nxt     = row_idx_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_rect_nxt    = out_rect_r;
    out_last_nxt    = out_last_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_FOREGROUND: fg_nxt = cfg_data;
        CFG_BACKGROUND: bg_nxt = cfg_data;
        CFG_SCALE:      scale_nxt = (cfg_data[SCALE_W-1:0] == '0) ? SCALE_W'(1)
                                                                  : cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            OP_PUT: begin
              if (in_code == CHAR_NEWLINE) begin
                cursor_col_nxt  = 8'd0;
                cursor_line_nxt = line_wrapped;
              end else if (in_code == CHAR_RETURN) begin
                cursor_col_nxt = 8'd0;
              end else begin
                if (in_code < GLYPH_FIRST || in_code > GLYPH_LAST) begin
                  code_idx_nxt = GLYPH_IDX_W'(GLYPH_SUBST - GLYPH_FIRST);
                end else begin
                  code_idx_nxt = GLYPH_IDX_W'(in_code - GLYPH_FIRST);
                end
                state_nxt = S_ORIGIN;
              end
            end
            OP_SET_POS: begin
              if (in_tcol < 8'(col_lim) && in_trow < 8'(row_lim)) begin
                cursor_col_nxt  = in_tcol;
                cursor_line_nxt = in_trow;
              end
            end
            OP_GOTO: begin
              cursor_col_nxt  = 8'd0;
              cursor_line_nxt = goto_line;
            end
            OP_HOME: begin
              cursor_col_nxt  = 8'd0;
              cursor_line_nxt = 8'd0;
            end
            OP_CLEAR: begin
              cursor_col_nxt       = 8'd0;
              cursor_line_nxt      = 8'd0;
              out_valid_nxt        = 1'b1;
              out_rect_nxt.x       = 8'd0;
              out_rect_nxt.y       = 8'd0;
              out_rect_nxt.w       = 8'(SCREEN_WIDTH);
              out_rect_nxt.h       = 8'(SCREEN_HEIGHT);
              out_rect_nxt.color   = bg_r;
              out_rect_nxt.visible = 1'b1;
              out_last_nxt         = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_ORIGIN: begin
        glyph_nxt   = GLYPH_ROM[code_idx_r];
        x_nxt       = origin_x;
        y_nxt       = origin_y;
        oy_nxt      = origin_y;
        col_idx_nxt = 3'd0;
        row_idx_nxt = 3'd0;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rect_nxt  = cell_rect;
          out_last_nxt  = cell_last;
          if (row_last) begin
            // skip the unused top bit of the column byte
            glyph_nxt   = {2'b00, glyph_r[39:2]};
            row_idx_nxt = 3'd0;
            col_idx_nxt = col_idx_r + 3'd1;
            x_nxt       = step_sum;
            y_nxt       = oy_r;
          end else begin
            glyph_nxt   = {1'b0, glyph_r[39:1]};
            row_idx_nxt = row_idx_r + 3'd1;
            y_nxt       = step_sum;
          end
          if (cell_last) begin
            state_nxt = S_CURSOR;
          end
        end
      end
      S_CURSOR: begin
        if ({2'b00, col_inc} >= 10'(col_lim)) begin
          cursor_col_nxt  = 8'd0;
          cursor_line_nxt = line_wrapped;
        end else begin
          cursor_col_nxt = col_inc;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fg_r          <= 16'hFFFF;
      bg_r          <= 16'h0000;
      scale_r       <= SCALE_W'(1);
      cursor_col_r  <= 8'd0;
      cursor_line_r <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fg_r          <= fg_nxt;
      bg_r          <= bg_nxt;
      scale_r       <= scale_nxt;
      cursor_col_r  <= cursor_col_nxt;
      cursor_line_r <= cursor_line_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_idx_r <= code_idx_nxt;
    glyph_r    <= glyph_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    oy_r       <= oy_nxt;
    col_idx_r  <= col_idx_nxt;
    row_idx_r  <= row_idx_nxt;
    out_rect_r <= out_rect_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rect_r.color, out_rect_r.h, out_rect_r.w,
                       out_rect_r.y, out_rect_r.x};
  assign out_tuser  = out_rect_r.visible;
  assign out_tlast  = out_last_r;

  `TTGR_ASSERT_IMP(a_col_bound, clk, rst_n, 1'b1, cursor_col_r < 8'(TEXT_COLUMNS), "cursor column beyond text columns")
  `TTGR_ASSERT_IMP(a_line_bound, clk, rst_n, 1'b1, cursor_line_r < 8'(TEXT_ROWS), "cursor line beyond text rows")
  `TTGR_ASSERT_IMP(a_emit_no_last, clk, rst_n, state_r == S_EMIT, !(out_valid_r && out_last_r), "stale last item held during glyph emission")
  `TTGR_ASSERT_NXT(a_last_to_cursor, clk, rst_n, (state_r == S_EMIT) && out_free && cell_last, state_r == S_CURSOR, "cursor update missed after last cell")

endmodule

[tb/tb_text_terminal_glyph_renderer.sv]
// Self-checking testbench of the character terminal: directed and random text streams.
`timescale 1ns / 1ps
module tb_text_terminal_glyph_renderer;
  import ttgr_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 7;
  // Longest quiet stretch of a correct run: the pressure-test sink hold, plus
  // the longest sender gap and one whole character, taken several times over.
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 50;
  localparam int PRESSURE_HOLD = 400;
  localparam int PHASE_ITEMS  = 27;
  localparam int PRINT_CAP    = 200;
  localparam int GLYPH_W      = 5;
  localparam int GLYPH_H      = 7;

  // 5x7 font, codes 0x20..0x7E, five column bytes per glyph, row 0 in bit 0
  localparam logic [7:0] FONT [GLYPH_COUNT * GLYPH_W] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00, 8'h00,8'h07,8'h00,8'h07,8'h00,
    8'h14,8'h7F,8'h14,8'h7F,8'h14, 8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00, 8'h00,8'h1C,8'h22,8'h41,8'h00,
    8'h00,8'h41,8'h22,8'h1C,8'h00, 8'h08,8'h2A,8'h1C,8'h2A,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08, 8'h00,8'h60,8'h60,8'h00,8'h00,
    8'h20,8'h10,8'h08,8'h04,8'h02, 8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31, 8'h18,8'h14,8'h12,8'h7F,8'h10,
    8'h27,8'h45,8'h45,8'h45,8'h39, 8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E, 8'h00,8'h36,8'h36,8'h00,8'h00,
    8'h00,8'h56,8'h36,8'h00,8'h00, 8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h41,8'h22,8'h14,8'h08,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06, 8'h32,8'h49,8'h79,8'h41,8'h3E,
    8'h7E,8'h11,8'h11,8'h11,8'h7E, 8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h01,8'h01,
    8'h3E,8'h41,8'h41,8'h51,8'h32, 8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41, 8'h7F,8'h40,8'h40,8'h40,8'h40,
    8'h7F,8'h02,8'h04,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46,
    8'h46,8'h49,8'h49,8'h49,8'h31, 8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F, 8'h63,8'h14,8'h08,8'h14,8'h63,
    8'h03,8'h04,8'h78,8'h04,8'h03, 8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h00,8'h7F,8'h41,8'h41,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h41,8'h41,8'h7F,8'h00,8'h00, 8'h04,8'h02,8'h01,8'h02,8'h04,
    8'h40,8'h40,8'h40,8'h40,8'h40, 8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20, 8'h38,8'h44,8'h44,8'h48,8'h7F,
    8'h38,8'h54,8'h54,8'h54,8'h18, 8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h08,8'h14,8'h54,8'h54,8'h3C,
    8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00, 8'h20,8'h40,8'h44,8'h3D,8'h00,
    8'h00,8'h7F,8'h10,8'h28,8'h44, 8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,
    8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38, 8'h7C,8'h14,8'h14,8'h14,8'h08,
    8'h08,8'h14,8'h14,8'h18,8'h7C, 8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
    8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C, 8'h1C,8'h20,8'h40,8'h20,8'h1C,
    8'h3C,8'h40,8'h30,8'h40,8'h3C, 8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
    8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00, 8'h00,8'h00,8'h7F,8'h00,8'h00,
    8'h00,8'h41,8'h36,8'h08,8'h00, 8'h08,8'h08,8'h2A,8'h1C,8'h08
  };

  // One rectangle the block should produce
  typedef struct {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [15:0] color;
    logic        visible;
    logic        last;
  } rect_exp_t;

  // All block inputs start at known values
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata  = '0;
  logic [2:0]           in_tuser  = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [47:0]          out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data  = '0;

  // Terminal model: registers and cursor, updated as items are accepted
  logic [15:0] model_fg    = 16'hFFFF;
  logic [15:0] model_bg    = 16'h0000;
  logic [3:0]  model_scale = 4'd1;
  logic [7:0]  cur_col     = '0;
  logic [7:0]  cur_line    = '0;

  rect_exp_t rects_due[$];   // expected rectangles, oldest first

  int errors       = 0;
  int idle_cycles  = 0;
  int sink_hold    = 0;      // cycles the sink still refuses, set by the pressure test
  int stall_left   = 0;
  bit steady_flow  = 1'b0;   // no random gaps on either side while set

  text_terminal_glyph_renderer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Terminal model
  // ---------------------------------------------------------------------------

  // Text grid shrinks with the scale but never below one cell.
  function automatic int unsigned col_limit();
    int unsigned m;
    m = TEXT_COLUMNS_DEF / model_scale;
    return (m == 0) ? 1 : m;
  endfunction

  function automatic int unsigned row_limit();
    int unsigned m;
    m = TEXT_ROWS_DEF / model_scale;
    return (m == 0) ? 1 : m;
  endfunction

  function automatic void next_line();
    cur_col  = '0;
    cur_line = cur_line + 8'd1;
    if (cur_line >= row_limit()) cur_line = '0;
  endfunction

  // Clip against the screen; an origin off screen gives an invisible, zero-sized item.
  function automatic void push_rect(input int unsigned x, input int unsigned y,
                                    input int unsigned w, input int unsigned h,
                                    input logic [15:0] color, input logic last);
    rect_exp_t r;
    r.color = color;
    r.last  = last;
    if (x < SCREEN_WIDTH_DEF && y < SCREEN_HEIGHT_DEF) begin
      if (x + w > SCREEN_WIDTH_DEF) w = SCREEN_WIDTH_DEF - x;
      if (y + h > SCREEN_HEIGHT_DEF) h = SCREEN_HEIGHT_DEF - y;
      r.visible = 1'b1;
      r.x = x[7:0];
      r.y = y[7:0];
      r.w = w[7:0];
      r.h = h[7:0];
    end else begin
      r.visible = 1'b0;
      r.x = '0;
      r.y = '0;
      r.w = '0;
      r.h = '0;
    end
    rects_due.push_back(r);
  endfunction

  // Expected rectangles and cursor motion for one accepted item.
  function automatic void predict_rects(input logic [2:0] op, input logic [7:0] code,
                                        input logic [7:0] tcol, input logic [7:0] trow,
                                        input logic [7:0] line_no);
    int unsigned s;
    int unsigned ox;
    int unsigned oy;
    int unsigned ln;
    logic [7:0]  glyph;
    logic [7:0]  bits;
    s = model_scale;
    case (op)
      OP_PUT: begin
        if (code == CHAR_NEWLINE) begin
          next_line();
        end else if (code == CHAR_RETURN) begin
          cur_col = '0;
        end else begin
          glyph = (code < GLYPH_FIRST || code > GLYPH_LAST) ? GLYPH_SUBST : code;
          ox = cur_col * CELL_WIDTH_DEF * s;
          oy = cur_line * CELL_HEIGHT_DEF * s;
          // glyph columns top to bottom, then the background gap column
          for (int c = 0; c < GLYPH_W; c++) begin
            bits = FONT[(glyph - GLYPH_FIRST) * GLYPH_W + c];
            for (int r = 0; r < GLYPH_H; r++)
              push_rect(ox + c * s, oy + r * s, s, s, bits[r] ? model_fg : model_bg, 1'b0);
          end
          for (int r = 0; r < GLYPH_H; r++)
            push_rect(ox + GLYPH_W * s, oy + r * s, s, s, model_bg, r == GLYPH_H - 1);
          // a cursor left beyond the grid by a scale change wraps here too
          cur_col = cur_col + 8'd1;
          if (cur_col >= col_limit()) next_line();
        end
      end
      OP_SET_POS: begin
        if (tcol < col_limit() && trow < row_limit()) begin
          cur_col  = tcol;
          cur_line = trow;
        end
      end
      OP_GOTO: begin
        ln = line_no;
        if (ln < 1) ln = 1;
        if (ln > row_limit()) ln = row_limit();
        cur_line = 8'(ln - 1);
        cur_col  = '0;
      end
      OP_HOME: begin
        cur_col  = '0;
        cur_line = '0;
      end
      OP_CLEAR: begin
        push_rect(0, 0, SCREEN_WIDTH_DEF, SCREEN_HEIGHT_DEF, model_bg, 1'b1);
        cur_col  = '0;
        cur_line = '0;
      end
      default: ;  // unused operation codes are dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Offer one item, wait for it to be taken, predict, then maybe idle.
  // With no gap, valid stays high and the next call only changes the data.
  task automatic send_item(input logic [2:0] op, input logic [7:0] code,
                           input logic [7:0] tcol, input logic [7:0] trow,
                           input logic [7:0] line_no);
    int gap;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {line_no, trow, tcol, code};
    do @(posedge clk); while (!in_tready);
    predict_rects(op, code, tcol, trow, line_no);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid, wait for every expected rectangle, then let the block settle.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (rects_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FOREGROUND: model_fg = value;
      CFG_BACKGROUND: model_bg = value;
      CFG_SCALE:      model_scale = (value[3:0] == 4'd0) ? 4'd1 : value[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [15:0] fg, input logic [15:0] bg,
                           input logic [15:0] scale_word);
    wait_idle();
    write_reg(CFG_FOREGROUND, fg);
    write_reg(CFG_BACKGROUND, bg);
    write_reg(CFG_SCALE, scale_word);
  endtask

  // Sink: the pressure hold wins, otherwise random stalls of random length.
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_tready = 1'b0;
      sink_hold  = sink_hold - 1;
    end else if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready = 1'b1;
      if (!steady_flow && $urandom_range(99) < 25) stall_left = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Prints are capped so a broken block cannot flood the log; all are counted.
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (errors < PRINT_CAP)
      $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    errors = errors + 1;
  endtask

  always @(posedge clk) begin : check_rect
    rect_exp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rects_due.size() == 0) begin
        report_mismatch("rectangle with none expected, x", 16'(out_tdata[7:0]), 16'h0);
      end else begin
        want = rects_due.pop_front();
        if (out_tdata[7:0] !== want.x)
          report_mismatch("rect_x", 16'(out_tdata[7:0]), 16'(want.x));
        if (out_tdata[15:8] !== want.y)
          report_mismatch("rect_y", 16'(out_tdata[15:8]), 16'(want.y));
        if (out_tdata[23:16] !== want.w)
          report_mismatch("rect_width", 16'(out_tdata[23:16]), 16'(want.w));
        if (out_tdata[31:24] !== want.h)
          report_mismatch("rect_height", 16'(out_tdata[31:24]), 16'(want.h));
        if (out_tdata[47:32] !== want.color)
          report_mismatch("pixel_color", out_tdata[47:32], want.color);
        if (out_tuser !== want.visible)
          report_mismatch("visible", 16'(out_tuser), 16'(want.visible));
        if (out_tlast !== want.last)
          report_mismatch("last", 16'(out_tlast), 16'(want.last));
      end
    end
  end

  // Watchdog: too long without any handshake means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("text_terminal_glyph_renderer test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset colors and scale: one glyph at the home cell, then a clear.
  task automatic test_reset_state();
    send_item(OP_PUT, "H", 8'h00, 8'h00, 8'h00);
    send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // Code extremes: control bytes and high codes draw '?', newline and
  // carriage return only move the cursor. Unused fields all ones.
  task automatic test_character_codes();
    logic [7:0] codes [9] = '{8'h00, 8'h1F, GLYPH_FIRST, GLYPH_SUBST, GLYPH_LAST,
                             8'h7F, 8'hFF, CHAR_RETURN, CHAR_NEWLINE};
    foreach (codes[i]) send_item(OP_PUT, codes[i], 8'hFF, 8'hFF, 8'hFF);
  endtask

  // Cursor commands at their limits.
  task automatic test_cursor_moves();
    send_item(OP_SET_POS, 8'h00, 8'd25, 8'd15, 8'h00);  // last cell of the grid
    send_item(OP_PUT, "A", 8'h00, 8'h00, 8'h00);        // wraps both column and line
    send_item(OP_SET_POS, 8'h00, 8'd26, 8'd0, 8'h00);   // column out of range: ignored
    send_item(OP_SET_POS, 8'h00, 8'd0, 8'd16, 8'h00);   // row out of range: ignored
    send_item(OP_SET_POS, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // both out of range
    send_item(OP_PUT, "B", 8'h00, 8'h00, 8'h00);
    send_item(OP_GOTO, 8'h00, 8'h00, 8'h00, 8'd0);      // clamps up to line 1
    send_item(OP_PUT, "C", 8'h00, 8'h00, 8'h00);
    send_item(OP_GOTO, 8'h00, 8'h00, 8'h00, 8'hFF);     // clamps down to the last line
    send_item(OP_PUT, "D", 8'h00, 8'h00, 8'h00);
    send_item(OP_SET_POS, 8'h00, 8'd3, 8'd15, 8'h00);
    send_item(OP_PUT, CHAR_NEWLINE, 8'h00, 8'h00, 8'h00);  // newline on the last row
    send_item(OP_HOME, 8'h00, 8'h00, 8'h00, 8'h00);
    // unused operations with every data bit set must do nothing
    for (int op = int'(OP_CLEAR) + 1; op < 8; op++)
      send_item(3'(op), 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_PUT, "E", 8'h00, 8'h00, 8'h00);
  endtask

  // Register extremes, the zero scale, large scales and clipping.
  task automatic test_register_settings();
    configure(16'h0000, 16'hFFFF, 16'h0000);  // zero scale stores one
    send_item(OP_PUT, "M", 8'h00, 8'h00, 8'h00);
    configure(16'hF800, 16'h001F, 16'h0008);
    send_item(OP_SET_POS, 8'h00, 8'd2, 8'd1, 8'h00);
    send_item(OP_PUT, "W", 8'h00, 8'h00, 8'h00);
    // cursor left beyond the grid by a larger scale: drawn off screen, then wraps
    configure(16'h07E0, 16'hA5A5, 16'h0001);
    send_item(OP_SET_POS, 8'h00, 8'd25, 8'd15, 8'h00);
    configure(16'h07E0, 16'hA5A5, 16'h0008);
    send_item(OP_PUT, "#", 8'h00, 8'h00, 8'h00);
    // right edge clipping: column 1 at scale 13, then drawn at scale 14
    configure(16'h1234, 16'h5678, 16'h000D);
    send_item(OP_SET_POS, 8'h00, 8'd1, 8'd0, 8'h00);
    configure(16'h1234, 16'h5678, 16'h000E);
    send_item(OP_PUT, "%", 8'h00, 8'h00, 8'h00);
    // bottom edge clipping: line 1 at scale 8, drawn at scale 15 (upper bits ignored)
    configure(16'hFFFF, 16'h0000, 16'h0008);
    send_item(OP_SET_POS, 8'h00, 8'd0, 8'd1, 8'h00);
    configure(16'hFFFF, 16'h0000, 16'hFFFF);
    send_item(OP_PUT, "@", 8'h00, 8'h00, 8'h00);
    send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // Sink refuses for a long stretch while the source keeps offering characters.
  task automatic test_output_pressure();
    configure(16'($urandom), 16'($urandom), 16'h0002);
    steady_flow = 1'b1;
    sink_hold   = PRESSURE_HOLD;
    for (int i = 0; i < 6; i++)
      send_item(OP_PUT, 8'($urandom_range(GLYPH_LAST, GLYPH_FIRST)), 8'h00, 8'h00, 8'h00);
    wait_idle();
    steady_flow = 1'b0;
  endtask

  // Random text streams under several settings. Most items are characters and
  // in-range cursor moves, the rest noise. The last phase runs with no idling.
  task automatic test_random_text();
    logic [15:0] scale_word;
    logic [31:0] fields;
    logic [2:0]  op;
    logic [7:0]  code, tcol, trow, line_no;
    int          roll;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       scale_word = 16'h0001;
        1:       scale_word = 16'($urandom_range(4, 2));
        2:       scale_word = 16'($urandom);        // any nibble, zero and 9..15 too
        default: scale_word = 16'($urandom_range(3, 1));
      endcase
      configure(16'($urandom), 16'($urandom), scale_word);
      steady_flow = (phase == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        fields  = $urandom;
        code    = fields[7:0];
        tcol    = fields[15:8];
        trow    = fields[23:16];
        line_no = fields[31:24];
        roll    = $urandom_range(99);
        if (roll < 60) begin
          op   = OP_PUT;
          roll = $urandom_range(99);
          if (roll < 75)      code = 8'($urandom_range(GLYPH_LAST, GLYPH_FIRST));
          else if (roll < 80) code = CHAR_NEWLINE;
          else if (roll < 85) code = CHAR_RETURN;
        end else if (roll < 75) begin
          op = OP_SET_POS;
          if ($urandom_range(99) < 80) begin
            tcol = 8'($urandom_range(col_limit() - 1));
            trow = 8'($urandom_range(row_limit() - 1));
          end
        end else if (roll < 83) begin
          op = OP_GOTO;
          if ($urandom_range(99) < 70) line_no = 8'($urandom_range(row_limit() + 1));
        end else if (roll < 88) begin
          op = OP_HOME;
        end else if (roll < 93) begin
          op = OP_CLEAR;
        end else begin
          op = 3'($urandom_range(7, int'(OP_CLEAR) + 1));
        end
        send_item(op, code, tcol, trow, line_no);
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_character_codes();
    test_cursor_moves();
    test_register_settings();
    test_output_pressure();
    test_random_text();

    wait_idle();
    if (errors == 0) begin
      $display("text_terminal_glyph_renderer test passed");
    end else begin
      $display("text_terminal_glyph_renderer test failed");
    end
    $finish;
  end

endmodule
